// ===== design/dmhm_pkg.sv =====
// ----------------------------------------------------------------------------
// dmhm_pkg
// Shared types and constants for the direct-mapped hash map.
// ----------------------------------------------------------------------------
`default_nettype none

package dmhm_pkg;

   localparam int CMD_W         = 2;
   localparam int KEY_W         = 8;
   localparam int VALUE_W       = 16;
   localparam int ENTRIES_W     = 5;
   localparam int HASH_W        = 16;
   localparam int SLOTS_DEFAULT = 16;

   // djb2 seed
   localparam logic [HASH_W-1:0] HASH_INIT = 16'd5381;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/direct_mapped_hash_map.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_hash_map
// Key/value table, one slot per bucket, djb2-hashed 8-bit keys.
// ----------------------------------------------------------------------------
// Each request word is an insert, lookup or remove of one 8-bit key; each
// gives exactly one response word carrying the lookup hit flag, the looked-up
// value (zero unless a lookup hits) and the number of occupied slots after the
// operation. The bucket is the djb2 hash of the key's decimal digits, least
// significant first, seeded with 5381, 16-bit wrap, modulo SLOTS. A slot holds
// one key; an insert into a slot owned by another key overwrites it, and a
// remove of a key not present changes nothing. Command code 3 is a no-op that
// still answers. Items run one at a time: a new request is accepted only
// once the previous one has reached its response register. Each request
// passes through the hash unit, d digit steps (d being the key's number of
// decimal digits, 0 for key zero, up to 3) plus two modulo steps, followed
// by the slot RAM read and the read-modify-write. The response sits in an
// output register, so the next request is taken while it waits for
// rsp_tready; an update stalls only while that register is full.
// Slot keys and values live in a RAM with no reset; occupancy is a valid bit
// per slot, cleared at reset, so the table is usable right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_hash_map #(
   parameter int SLOTS = dmhm_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] cmd, [9:2] key, [25:10] value, [31:26] zero
   input  wire logic [31:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] hit, [16:1] read_value, [21:17] entries, [23:22] zero
   output logic [23:0]      rsp_tdata
);

   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int KEY_W     = dmhm_pkg::KEY_W;
   localparam int VALUE_W   = dmhm_pkg::VALUE_W;
   localparam int ENTRIES_W = dmhm_pkg::ENTRIES_W;
   localparam int CMD_W     = dmhm_pkg::CMD_W;
   localparam int SLOT_W    = KEY_W + VALUE_W;

   typedef enum logic [1:0] {
      T_IDLE,
      T_HASH,
      T_UPDATE
   } tstate_type;

   tstate_type                state_ff, state_in;
   dmhm_pkg::cmd_type         cmd_ff, cmd_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic [VALUE_W-1:0]        value_ff, value_in;
   logic [IDX_W-1:0]          bucket_ff, bucket_in;
   logic [SLOTS-1:0]          valid_ff, valid_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [ENTRIES_W-1:0]      rsp_entries_ff, rsp_entries_in;

   logic                      accept;
   logic                      hash_done;
   logic [IDX_W-1:0]          hash_bucket;
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [SLOT_W-1:0]         ram_rd_data;
   logic [KEY_W-1:0]          slot_key;
   logic [VALUE_W-1:0]        slot_value;
   logic                      slot_valid;
   logic                      match;
   logic                      commit;
   logic [CNT_W+ENTRIES_W-1:0] count_ext;

   // take a request only when no item is in flight
   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;

   dmhm_hash #(
      .SLOTS (SLOTS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .key    (req_tdata[CMD_W +: KEY_W]),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // slot store: {value, key}
   dmhm_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bucket_ff),
      .wr_data ({value_ff, key_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (hash_bucket),
      .rd_data (ram_rd_data)
   );

   assign slot_key   = ram_rd_data[KEY_W-1:0];
   assign slot_value = ram_rd_data[SLOT_W-1:KEY_W];
   assign slot_valid = valid_ff[bucket_ff];
   assign match      = slot_valid && (slot_key == key_ff);

   // finish the update only when the response register is free this cycle
   assign commit = (state_ff == T_UPDATE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      bucket_in      = bucket_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_entries_in = rsp_entries_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      count_ext      = '0;

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               cmd_in   = dmhm_pkg::cmd_type'(req_tdata[CMD_W-1:0]);
               key_in   = req_tdata[CMD_W +: KEY_W];
               value_in = req_tdata[CMD_W+KEY_W +: VALUE_W];
               state_in = T_HASH;
            end
         end
         T_HASH: begin
            // issue the slot read as the bucket lands
            if (hash_done) begin
               ram_rd_en = 1'b1;
               bucket_in = hash_bucket;
               state_in  = T_UPDATE;
            end
         end
         T_UPDATE: begin
            if (commit) begin
               rsp_hit_in   = 1'b0;
               rsp_value_in = '0;
               case (cmd_ff)
                  dmhm_pkg::CMD_INSERT: begin
                     ram_wr_en = 1'b1;
                     if (!slot_valid) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     valid_in[bucket_ff] = 1'b1;
                  end
                  dmhm_pkg::CMD_LOOKUP: begin
                     if (match) begin
                        rsp_hit_in   = 1'b1;
                        rsp_value_in = slot_value;
                     end
                  end
                  dmhm_pkg::CMD_REMOVE: begin
                     if (match) begin
                        valid_in[bucket_ff] = 1'b0;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     // unused code: answer, change nothing
                  end
               endcase
               count_ext      = (CNT_W+ENTRIES_W)'(count_in);
               rsp_entries_in = count_ext[ENTRIES_W-1:0];
               rsp_valid_in   = 1'b1;
               state_in       = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      bucket_ff      <= bucket_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_entries_ff, rsp_value_ff, rsp_hit_ff};

endmodule

`default_nettype wire

// ===== design/dmhm_ram.sv =====
// ----------------------------------------------------------------------------
// dmhm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/dmhm_hash.sv =====
// ----------------------------------------------------------------------------
// dmhm_hash
// Iterative djb2 bucket unit: one decimal digit per cycle, then the
// 16-bit hash reduced modulo SLOTS eight bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmhm_hash #(
   parameter int SLOTS = dmhm_pkg::SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [dmhm_pkg::KEY_W-1:0]   key,
   output logic                              done,
   output logic      [$clog2(SLOTS)-1:0]     bucket
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W:0] SLOTS_T = (IDX_W+1)'(SLOTS);
   localparam int KEY_W = dmhm_pkg::KEY_W;
   localparam int HASH_W = dmhm_pkg::HASH_W;
   // k / 10 as (k * 205) >> 11, exact for 8-bit k
   localparam logic [7:0] RECIP_10 = 8'd205;
   localparam int RECIP_SH = 11;

   typedef enum logic [1:0] {
      H_IDLE,
      H_DIGIT,
      H_MOD_HI,
      H_MOD_LO
   } hstate_type;

   hstate_type         state_ff, state_in;
   logic [KEY_W-1:0]   k_ff, k_in;
   logic [HASH_W-1:0]  h_ff, h_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic               done_ff, done_in;

   logic [KEY_W+7:0]   prod;
   logic [KEY_W-1:0]   quot;
   logic [KEY_W-1:0]   digit;
   logic [7:0]         mod_byte;
   logic [IDX_W-1:0]   mod_rem;
   logic [IDX_W:0]     trial;

   always_comb begin
      prod  = (KEY_W+8)'(k_ff) * (KEY_W+8)'(RECIP_10);
      quot  = KEY_W'(prod >> RECIP_SH);
      digit = k_ff - KEY_W'(quot * KEY_W'(10));

      // restoring remainder over one byte of the hash
      mod_byte = (state_ff == H_MOD_HI) ? h_ff[HASH_W-1:8] : h_ff[7:0];
      mod_rem  = (state_ff == H_MOD_HI) ? '0 : rem_ff;
      for (int i = 7; i >= 0; i--) begin
         trial = {mod_rem, mod_byte[i]};
         if (trial >= SLOTS_T) begin
            trial = trial - SLOTS_T;
         end
         mod_rem = trial[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      h_in     = h_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               k_in     = key;
               h_in     = dmhm_pkg::HASH_INIT;
               state_in = (key == '0) ? H_MOD_HI : H_DIGIT;
            end
         end
         H_DIGIT: begin
            h_in = (h_ff << 5) + h_ff + HASH_W'(digit);
            k_in = quot;
            if (quot == '0) begin
               state_in = H_MOD_HI;
            end
         end
         H_MOD_HI: begin
            rem_in   = mod_rem;
            state_in = H_MOD_LO;
         end
         H_MOD_LO: begin
            rem_in   = mod_rem;
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      k_ff   <= k_in;
      h_ff   <= h_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct-mapped hash map.
// ----------------------------------------------------------------------------
// A shadow copy of the slot table predicts the response word for every
// accepted request word. Responses are checked in order, field by field. A
// short directed run covers the cases that matter: key zero, keys with one to
// three digits, overwrites, misses, removes and the unused command code. Then
// four random phases follow, each with its own idle and stall pattern.
// ----------------------------------------------------------------------------

module tb;

   import dmhm_pkg::*;

   localparam int                TABLE_SLOTS      = SLOTS_DEFAULT;
   localparam logic [CMD_W-1:0]  CMD_NOP          = 2'd3;  // unused code, answers with no hit and a zero value
   localparam int                POOL_SIZE        = 24;
   localparam int                RANDOM_PER_PHASE = 225;
   localparam int                LONG_HOLD_CYCLES = 300;
   localparam int                STALL_LIMIT      = 2000;
   localparam int                DRAIN_CYCLES     = 20;

   // Response word layout, lowest bit last.
   typedef struct packed {
      logic [1:0]           pad;
      logic [ENTRIES_W-1:0] entries;
      logic [VALUE_W-1:0]   read_value;
      logic                 hit;
   } rsp_word_t;

   // Shadow of the slot table. It keeps the expected response words in the
   // order their requests were accepted.
   class hash_table_shadow;
      logic [KEY_W-1:0]   slot_key   [TABLE_SLOTS];
      logic [VALUE_W-1:0] slot_value [TABLE_SLOTS];
      bit                 slot_valid [TABLE_SLOTS];
      int unsigned        entry_count;
      rsp_word_t          pending_responses [$];
      int                 fail_count;

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         entry_count = 0;
         fail_count  = 0;
      endfunction

      // djb2 over the decimal digits, least significant first, 16-bit wrap
      function int unsigned bucket_index(logic [KEY_W-1:0] key);
         logic [HASH_W-1:0] hash;
         int unsigned       rest;
         hash = HASH_INIT;
         rest = key;
         while (rest != 0) begin
            hash = (hash << 5) + hash + HASH_W'(rest % 10);
            rest = rest / 10;
         end
         return hash % TABLE_SLOTS;
      endfunction

      function void note_request(logic [31:0] word);
         logic [CMD_W-1:0]   op;
         logic [KEY_W-1:0]   key;
         logic [VALUE_W-1:0] value;
         int unsigned        b;
         bit                 match;
         rsp_word_t          rsp;
         op    = word[1:0];
         key   = word[9:2];
         value = word[25:10];
         b     = bucket_index(key);
         match = slot_valid[b] && (slot_key[b] == key);
         rsp   = '0;
         case (op)
            CMD_INSERT: begin
               if (!slot_valid[b]) entry_count++;
               slot_key[b]   = key;
               slot_value[b] = value;
               slot_valid[b] = 1'b1;
            end
            CMD_LOOKUP: begin
               if (match) begin
                  rsp.hit        = 1'b1;
                  rsp.read_value = slot_value[b];
               end
            end
            CMD_REMOVE: begin
               if (match) begin
                  slot_valid[b] = 1'b0;
                  entry_count--;
               end
            end
            default: ;
         endcase
         rsp.entries = ENTRIES_W'(entry_count);
         pending_responses.push_back(rsp);
      endfunction

      task report_mismatch(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
         fail_count++;
         $display("ERROR at %0t: %s got %0h expected %0h", $time, field, got, want);
      endtask

      task check_response(logic [23:0] word);
         rsp_word_t got;
         rsp_word_t want;
         got = word;
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response, entries", 16'(got.entries), '0);
            return;
         end
         want = pending_responses.pop_front();
         if (got.hit !== want.hit)
            report_mismatch("hit", 16'(got.hit), 16'(want.hit));
         if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
         if (got.entries !== want.entries)
            report_mismatch("entries", 16'(got.entries), 16'(want.entries));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   hash_table_shadow ledger;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int               req_idle_pct      = 0;
   int               rsp_stall_pct     = 0;
   bit               long_hold_request = 1'b0;
   int               quiet_cycles      = 0;

   direct_mapped_hash_map i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [1:0] cmd, [9:2] key, [25:10] value, [31:26] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)      // [0] hit, [16:1] read_value, [21:17] entries, [23:22] zero
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Record every request word and check every response word on the
   // rising edge at which it is accepted.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         ledger.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_response(rsp_tdata);
   end

   // Give up once nothing has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
         $display("direct_mapped_hash_map test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: stall at random; on request, hold off for a long stretch
   // so the block fills up and backs up its input.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one request word; idle at random first. Call and return at a
   // falling edge.
   task automatic send_request(logic [CMD_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, value, key, op};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (ledger.pending_responses.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_item();
      int                 pick;
      logic [CMD_W-1:0]   op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = CMD_INSERT;
      else if (pick < 75) op = CMD_LOOKUP;
      else if (pick < 95) op = CMD_REMOVE;
      else                op = CMD_NOP;
      // Half the keys come from a small pool so lookups and removes find them.
      if ($urandom_range(0, 1) == 1)
         key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         key = KEY_W'($urandom_range(0, 255));
      value = VALUE_W'($urandom_range(0, 65535));
      send_request(op, key, value);
   endtask

   task automatic run_directed();
      logic [KEY_W-1:0] rival;
      bit               found;
      // Find another key that lands in the same bucket as 100.
      found = 1'b0;
      rival = '0;
      for (int k = 1; k < 256; k++) begin
         if (!found && k != 100 &&
             ledger.bucket_index(KEY_W'(k)) == ledger.bucket_index(8'd100)) begin
            rival = KEY_W'(k);
            found = 1'b1;
         end
      end
      // Empty table: miss, and a remove that changes nothing.
      send_request(CMD_LOOKUP, 8'd0,   16'h0000);
      send_request(CMD_REMOVE, 8'd0,   16'h0000);
      // Key zero has no digits; fill, then update in place.
      send_request(CMD_INSERT, 8'd0,   16'h8000);
      send_request(CMD_LOOKUP, 8'd0,   16'h0000);
      send_request(CMD_INSERT, 8'd0,   16'h7FFF);
      send_request(CMD_LOOKUP, 8'd0,   16'hFFFF);
      // One, two and three digit keys.
      send_request(CMD_INSERT, 8'd255, 16'h0000);
      send_request(CMD_INSERT, 8'd9,   16'hFFFF);
      send_request(CMD_INSERT, 8'd10,  16'h5A5A);
      send_request(CMD_INSERT, 8'd99,  16'hA5A5);
      send_request(CMD_INSERT, 8'd100, 16'h1234);
      send_request(CMD_LOOKUP, 8'd255, 16'h0000);
      send_request(CMD_LOOKUP, 8'd9,   16'h0000);
      send_request(CMD_LOOKUP, 8'd100, 16'h0000);
      // A different key in the same bucket evicts the old owner.
      send_request(CMD_INSERT, rival,  16'hCAFE);
      send_request(CMD_LOOKUP, 8'd100, 16'h0000);
      send_request(CMD_LOOKUP, rival,  16'h0000);
      send_request(CMD_REMOVE, 8'd100, 16'h0000);
      send_request(CMD_REMOVE, rival,  16'h0000);
      send_request(CMD_LOOKUP, rival,  16'h0000);
      // Unused command code answers with no hit and a zero value; value ignored.
      send_request(CMD_NOP,    8'd9,   16'hFFFF);
      send_request(CMD_LOOKUP, 8'd9,   16'h0000);
   endtask

   initial begin
      ledger = new();
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = KEY_W'($urandom_range(0, 255));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 48; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin req_idle_pct = 7;  rsp_stall_pct = 7;  end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Hold the response side off while requests keep coming.
            if (phase == 0 && n == 40) long_hold_request = 1'b1;
            send_random_item();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (ledger.fail_count == 0)
         $display("direct_mapped_hash_map test passed");
      else
         $display("direct_mapped_hash_map test failed");
      $finish;
   end

endmodule
